>>> hw/rtl/assert_macros.svh
// Assertion macros used by mips_alu_mul_div_unit.sv. They compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) `ASSERT_PROP(lbl, clk, rstn, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/mmdu_pkg.sv
`default_nettype none
package mmdu_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned OpW     = 5;
  localparam int unsigned RegIdxW = 5;
  localparam int unsigned InDataW = 96;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned StepCntW = 5;
  localparam logic [StepCntW-1:0] LastStep = 5'd31;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 5'd0,
    OP_ADDU  = 5'd1,
    OP_ADDI  = 5'd2,
    OP_ADDIU = 5'd3,
    OP_SUB   = 5'd4,
    OP_SUBU  = 5'd5,
    OP_MULT  = 5'd6,
    OP_MULTU = 5'd7,
    OP_DIV   = 5'd8,
    OP_DIVU  = 5'd9,
    OP_MFHI  = 5'd10,
    OP_MFLO  = 5'd11,
    OP_MTHI  = 5'd12,
    OP_MTLO  = 5'd13,
    OP_SLT   = 5'd14,
    OP_SLTU  = 5'd15,
    OP_SLTI  = 5'd16,
    OP_SLTIU = 5'd17
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_MULDIV
  } top_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_ITER,
    MD_FIX_LO,
    MD_FIX_HI,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/mmdu_muldiv.sv
`default_nettype none
// Multiplies by shift-and-add and divides by restoring shift-and-subtract,
// one bit per cycle through a single adder, then fixes the signs in two steps.
module mmdu_muldiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mmdu_pkg::md_ctrl_t            ctrl,
  input  wire logic [mmdu_pkg::WordW-1:0]    op_a,
  input  wire logic [mmdu_pkg::WordW-1:0]    op_b,
  output mmdu_pkg::md_stat_t                 stat,
  output logic      [mmdu_pkg::WordW-1:0]    hi_result,
  output logic      [mmdu_pkg::WordW-1:0]    lo_result
);

  mmdu_pkg::md_state_t state_r, state_nxt;
  logic [mmdu_pkg::StepCntW-1:0] cnt_r, cnt_nxt;
  logic [mmdu_pkg::WordW-1:0] hi_r, hi_nxt, lo_r, lo_nxt, opnd_r, opnd_nxt;
  logic is_div_r, is_div_nxt;
  logic neg_lo_r, neg_lo_nxt, neg_hi_r, neg_hi_nxt, carry_r, carry_nxt;

  logic [mmdu_pkg::WordW-1:0] mag_a, mag_b;
  logic [mmdu_pkg::WordW:0]   add_x, add_y, mul_acc;
  logic [mmdu_pkg::WordW+1:0] add_sum;
  logic                       hi_cin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmdu_pkg::MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    opnd_r   <= opnd_nxt;
    is_div_r <= is_div_nxt;
    neg_lo_r <= neg_lo_nxt;
    neg_hi_r <= neg_hi_nxt;
    carry_r  <= carry_nxt;
  end

  always_comb begin
    mag_a = (ctrl.is_signed && op_a[mmdu_pkg::WordW-1]) ? (~op_a + 32'd1) : op_a;
    mag_b = (ctrl.is_signed && op_b[mmdu_pkg::WordW-1]) ? (~op_b + 32'd1) : op_b;

    add_x   = is_div_r ? {hi_r, lo_r[mmdu_pkg::WordW-1]} : {1'b0, hi_r};
    add_y   = {1'b0, opnd_r};
    add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {34{is_div_r}}) + {33'd0, is_div_r};
    mul_acc = lo_r[0] ? add_sum[mmdu_pkg::WordW:0] : {1'b0, hi_r};
    hi_cin  = is_div_r ? neg_hi_r : carry_r;

    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    opnd_nxt   = opnd_r;
    is_div_nxt = is_div_r;
    neg_lo_nxt = neg_lo_r;
    neg_hi_nxt = neg_hi_r;
    carry_nxt  = carry_r;
    stat.busy  = (state_r != mmdu_pkg::MD_IDLE);
    stat.done  = 1'b0;

    unique case (state_r)
      mmdu_pkg::MD_IDLE: begin
        if (ctrl.start) begin
          state_nxt  = mmdu_pkg::MD_ITER;
          cnt_nxt    = '0;
          hi_nxt     = '0;
          is_div_nxt = ctrl.is_div;
          carry_nxt  = 1'b0;
          neg_lo_nxt = ctrl.is_signed && (op_a[mmdu_pkg::WordW-1] ^ op_b[mmdu_pkg::WordW-1]);
          if (ctrl.is_div) begin
            lo_nxt     = mag_a;
            opnd_nxt   = mag_b;
            neg_hi_nxt = ctrl.is_signed && op_a[mmdu_pkg::WordW-1];
          end else begin
            lo_nxt     = mag_b;
            opnd_nxt   = mag_a;
            neg_hi_nxt = ctrl.is_signed && (op_a[mmdu_pkg::WordW-1] ^ op_b[mmdu_pkg::WordW-1]);
          end
        end
      end
      mmdu_pkg::MD_ITER: begin
        if (is_div_r) begin
          hi_nxt = add_sum[mmdu_pkg::WordW+1] ? add_x[mmdu_pkg::WordW-1:0]
                                               : add_sum[mmdu_pkg::WordW-1:0];
          lo_nxt = {lo_r[mmdu_pkg::WordW-2:0], ~add_sum[mmdu_pkg::WordW+1]};
        end else begin
          hi_nxt = mul_acc[mmdu_pkg::WordW:1];
          lo_nxt = {mul_acc[0], lo_r[mmdu_pkg::WordW-1:1]};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == mmdu_pkg::LastStep) begin
          state_nxt = mmdu_pkg::MD_FIX_LO;
        end
      end
      mmdu_pkg::MD_FIX_LO: begin
        {carry_nxt, lo_nxt} = {1'b0, lo_r ^ {32{neg_lo_r}}} + {32'd0, neg_lo_r};
        state_nxt = mmdu_pkg::MD_FIX_HI;
      end
      mmdu_pkg::MD_FIX_HI: begin
        hi_nxt    = (hi_r ^ {32{neg_hi_r}}) + {31'd0, hi_cin};
        state_nxt = mmdu_pkg::MD_DONE;
      end
      mmdu_pkg::MD_DONE: begin
        stat.done = 1'b1;
        state_nxt = mmdu_pkg::MD_IDLE;
      end
      default: begin
        state_nxt = mmdu_pkg::MD_IDLE;
      end
    endcase
  end

  assign hi_result = hi_r;
  assign lo_result = lo_r;

endmodule
`default_nettype wire

>>> hw/rtl/mips_alu_mul_div_unit.sv
`default_nettype none
`include "assert_macros.svh"
// Executes one MIPS integer arithmetic instruction per transfer and keeps the HI/LO pair.
// Add, subtract, set-less-than and the HI/LO moves finish in the transfer cycle and their
// result appears on the output register in the next cycle. MULT, MULTU, DIV and DIVU run
// through a single 34-bit adder one bit per cycle (32 steps), then take two sign-correction
// steps and a completion state in which HI, LO and the output register are loaded. The unit
// holds in_tready low meanwhile, so no new instruction is taken until that result is loaded.
// Every instruction gives exactly one result transfer, also those that
// write no register. A finished result may wait in the output register while the next
// simple instruction is taken, provided the output side drains it in that same cycle.
module mips_alu_mul_div_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // instruction [31:0], rs_value [63:32], rt_value [95:64]
  input  wire logic [mmdu_pkg::InDataW-1:0]     in_tdata,
  // operation [4:0]
  input  wire logic [mmdu_pkg::OpW-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // write_index [4:0], write_value [36:5], zero [39:37]
  output logic      [mmdu_pkg::OutDataW-1:0]    out_tdata,
  // write_enable [0], overflow_trap [1]
  output logic      [mmdu_pkg::OutUserW-1:0]    out_tuser
);

  mmdu_pkg::top_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [mmdu_pkg::OutDataW-1:0] out_data_r, out_data_nxt;
  logic [mmdu_pkg::OutUserW-1:0] out_user_r, out_user_nxt;
  logic [mmdu_pkg::WordW-1:0] hi_r, hi_nxt, lo_r, lo_nxt;

  mmdu_pkg::op_t op;
  logic [mmdu_pkg::WordW-1:0] instr, a, b, imm, sum_rr, sum_ri, diff, res_val;
  logic [mmdu_pkg::RegIdxW-1:0] rt_idx, rd_idx, res_idx;
  logic accept, res_we, res_trap, load_out;
  mmdu_pkg::md_ctrl_t md_ctrl;
  mmdu_pkg::md_stat_t md_stat;
  logic [mmdu_pkg::WordW-1:0] md_hi, md_lo;

  mmdu_muldiv u_muldiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (md_ctrl),
    .op_a      (a),
    .op_b      (b),
    .stat      (md_stat),
    .hi_result (md_hi),
    .lo_result (md_lo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmdu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      hi_r        <= '0;
      lo_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    op     = mmdu_pkg::op_t'(in_tuser);
    instr  = in_tdata[31:0];
    a      = in_tdata[63:32];
    b      = in_tdata[95:64];
    rt_idx = instr[20:16];
    rd_idx = instr[15:11];
    imm    = {{16{instr[15]}}, instr[15:0]};
    sum_rr = a + b;
    sum_ri = a + imm;
    diff   = a - b;

    in_tready = (state_r == mmdu_pkg::ST_IDLE) && (!out_valid_r || out_tready);
    accept    = in_tvalid && in_tready;

    res_we   = 1'b0;
    res_idx  = '0;
    res_val  = '0;
    res_trap = 1'b0;
    md_ctrl  = '0;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;

    unique case (op) inside
      mmdu_pkg::OP_ADD: begin
        res_idx = rd_idx;
        if ((a[31] == b[31]) && (sum_rr[31] != a[31])) begin
          res_trap = 1'b1;
        end else begin
          res_we  = 1'b1;
          res_val = sum_rr;
        end
      end
      mmdu_pkg::OP_ADDI: begin
        res_idx = rt_idx;
        if ((a[31] == imm[31]) && (sum_ri[31] != a[31])) begin
          res_trap = 1'b1;
        end else begin
          res_we  = 1'b1;
          res_val = sum_ri;
        end
      end
      mmdu_pkg::OP_SUB: begin
        res_idx = rd_idx;
        if ((a[31] != b[31]) && (diff[31] != a[31])) begin
          res_trap = 1'b1;
        end else begin
          res_we  = 1'b1;
          res_val = diff;
        end
      end
      mmdu_pkg::OP_ADDU: begin
        res_we = 1'b1; res_idx = rd_idx; res_val = sum_rr;
      end
      mmdu_pkg::OP_ADDIU: begin
        res_we = 1'b1; res_idx = rt_idx; res_val = sum_ri;
      end
      mmdu_pkg::OP_SUBU: begin
        res_we = 1'b1; res_idx = rd_idx; res_val = diff;
      end
      mmdu_pkg::OP_MULT, mmdu_pkg::OP_MULTU, mmdu_pkg::OP_DIV, mmdu_pkg::OP_DIVU: begin
        md_ctrl.start     = accept;
        md_ctrl.is_div    = (op == mmdu_pkg::OP_DIV) || (op == mmdu_pkg::OP_DIVU);
        md_ctrl.is_signed = (op == mmdu_pkg::OP_MULT) || (op == mmdu_pkg::OP_DIV);
      end
      mmdu_pkg::OP_MFHI: begin
        res_we = 1'b1; res_idx = rd_idx; res_val = hi_r;
      end
      mmdu_pkg::OP_MFLO: begin
        res_we = 1'b1; res_idx = rd_idx; res_val = lo_r;
      end
      mmdu_pkg::OP_MTHI: begin
        if (accept) begin
          hi_nxt = a;
        end
      end
      mmdu_pkg::OP_MTLO: begin
        if (accept) begin
          lo_nxt = a;
        end
      end
      mmdu_pkg::OP_SLT: begin
        res_we = 1'b1; res_idx = rd_idx;
        res_val = {31'd0, ({~a[31], a[30:0]} < {~b[31], b[30:0]})};
      end
      mmdu_pkg::OP_SLTU: begin
        res_we = 1'b1; res_idx = rd_idx; res_val = {31'd0, (a < b)};
      end
      mmdu_pkg::OP_SLTI: begin
        res_we = 1'b1; res_idx = rt_idx;
        res_val = {31'd0, ({~a[31], a[30:0]} < {~imm[31], imm[30:0]})};
      end
      mmdu_pkg::OP_SLTIU: begin
        res_we = 1'b1; res_idx = rt_idx; res_val = {31'd0, (a < imm)};
      end
      default: begin
      end
    endcase

    state_nxt    = state_r;
    load_out     = 1'b0;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;

    unique case (state_r)
      mmdu_pkg::ST_IDLE: begin
        if (accept) begin
          if (md_ctrl.start) begin
            state_nxt = mmdu_pkg::ST_MULDIV;
          end else begin
            load_out     = 1'b1;
            out_data_nxt = {3'd0, res_val, res_idx};
            out_user_nxt = {res_trap, res_we};
          end
        end
      end
      mmdu_pkg::ST_MULDIV: begin
        if (md_stat.done) begin
          hi_nxt       = md_hi;
          lo_nxt       = md_lo;
          load_out     = 1'b1;
          out_data_nxt = '0;
          out_user_nxt = '0;
          state_nxt    = mmdu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmdu_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && !out_tready);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `ASSERT_NEVER(a_no_accept_while_busy, clk, rst_n, in_tready && md_stat.busy)
  `ASSERT_NEVER(a_done_only_in_muldiv, clk, rst_n, md_stat.done && (state_r != mmdu_pkg::ST_MULDIV))
  `ASSERT_PROP(a_done_gives_result, clk, rst_n, md_stat.done |=> out_valid_r)
  `ASSERT_NEVER(a_trap_blocks_write, clk, rst_n, out_valid_r && out_user_r[1] && out_user_r[0])

endmodule
`default_nettype wire
